>>> hw/rtl/tss_pkg.sv
// Shared types and constants for the texture store sampler.
// Used by the front end, the request queue, the back end and the top level.
`timescale 1ns / 1ps

package tss_pkg;

  localparam int unsigned MAX_WIDTH  = 128;
  localparam int unsigned MAX_HEIGHT = 128;
  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned SZ_W   = 8;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_READ     = 2'd1,
    REQ_NEAREST  = 2'd2,
    REQ_BILINEAR = 2'd3
  } req_e;

  // One classified request as it waits in the queue.
  typedef struct packed {
    req_e              kind;
    logic              drop;    // write or read outside the texture
    logic [XW-1:0]     x0;
    logic [XW-1:0]     x1;
    logic [YW-1:0]     y0;
    logic [YW-1:0]     y1;
    logic [15:0]       fx;
    logic [15:0]       fy;
    logic [31:0]       color;
    logic [SZ_W-1:0]   w;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } stat_t;

endpackage

>>> hw/rtl/texture_store_sampler.sv
// Top level of the texture store sampler: front end, request queue, back end.
// Depends on tss_pkg, tss_front, tss_queue and tss_back.
`timescale 1ns / 1ps

// RGBA8 texture store with texel write and read, nearest and bilinear
// repeat-wrapped sampling. After reset a clearing pass writes transparent
// black to all 16384 texels, one per cycle; no request beat is taken during
// the clearing pass, while configuration writes are taken at any time.
// Requests are classified in the front end and wait in a four-entry queue.
// The back end uses one memory port. A write, a read or a nearest sample
// makes at most one access; a bilinear sample makes four texel fetches
// through the single port, then passes the weight and blend pipeline. A
// result is held in an output register, so the next request may start
// while it waits.
module texture_store_sampler import tss_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // pos_x, pos_y, coord_u, coord_v, in_red, in_green, in_blue, in_alpha
  input  logic [127:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0]   m_axis_tdata,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  stat_t  stat;
  entry_t push_entry, head_entry;
  logic   q_push, q_pop, q_full, q_empty;

  tss_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .stat_i  (stat),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (push_entry)
  );

  tss_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .entry_o (head_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tss_back u_back (
    .clk_i, .rst_ni,
    .entry_i (head_entry),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .stat_o  (stat),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // No request is taken while the memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !s_axis_tready)
    else $error("request accepted during clearing pass");

  // The queue is never pushed when full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("queue overflow");

  // No result appears before the clearing pass is over.
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !m_axis_tvalid)
    else $error("result during clearing pass");

endmodule

>>> hw/rtl/tss_front.sv
// Front end: takes request beats and configuration writes, classifies requests.
// Depends on tss_pkg; feeds tss_queue.
`timescale 1ns / 1ps

module tss_front import tss_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // pos_x, pos_y, coord_u, coord_v, in_red, in_green, in_blue, in_alpha
  input  logic [127:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]    s_axis_tuser,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  input  stat_t         stat_i,
  input  logic          full_i,
  output logic          push_o,
  output entry_t        entry_o
);

  typedef struct packed {
    logic [SZ_W-1:0] i0;
    logic [SZ_W-1:0] i1;
    logic [15:0]     fr;
  } axis_t;

  logic [7:0] width_q, width_d, height_q, height_d;
  logic [SZ_W-1:0] w_eff, h_eff;
  logic signed [15:0] px, py;
  logic [15:0] fu, fv;
  logic in_tex;
  logic [23:0] nx, ny;
  axis_t ax, ay;

  // Half-texel offset, floor and wrap of both neighbours along one axis.
  function automatic axis_t bil_axis(input logic [15:0] f, input logic [SZ_W-1:0] n);
    logic [24:0] t;
    logic [8:0]  ip1;
    axis_t       r;
    t    = 25'(f) * 25'(n) + 25'd32768;
    ip1  = t[24:16];
    r.fr = t[15:0];
    r.i1 = (ip1 == 9'(n)) ? '0 : ip1[SZ_W-1:0];
    r.i0 = (ip1 == 9'd0) ? n - 1'b1 : SZ_W'(ip1 - 9'd1);
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TEX_WIDTH:  width_d  = cfg_data_i;
        REG_TEX_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'(MAX_WIDTH);
      height_q <= 8'(MAX_HEIGHT);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // A zero size acts as one; a size above the maximum acts as the maximum.
  assign w_eff = (width_q == '0) ? SZ_W'(1) :
                 (32'(width_q) > MAX_WIDTH) ? SZ_W'(MAX_WIDTH) : width_q;
  assign h_eff = (height_q == '0) ? SZ_W'(1) :
                 (32'(height_q) > MAX_HEIGHT) ? SZ_W'(MAX_HEIGHT) : height_q;

  assign px = s_axis_tdata[15:0];
  assign py = s_axis_tdata[31:16];
  assign fu = s_axis_tdata[47:32];
  assign fv = s_axis_tdata[79:64];
  assign in_tex = !px[15] && !py[15] &&
                  (px[15:0] < 16'(w_eff)) && (py[15:0] < 16'(h_eff));

  assign nx = 24'(fu) * 24'(w_eff);
  assign ny = 24'(fv) * 24'(h_eff);
  assign ax = bil_axis(fu, w_eff);
  assign ay = bil_axis(fv, h_eff);

  // Classify the request and work out its texel coordinates.
  always_comb begin
    entry_o       = '0;
    entry_o.kind  = req_e'(s_axis_tuser);
    entry_o.color = s_axis_tdata[127:96];
    entry_o.w     = w_eff;
    case (req_e'(s_axis_tuser))
      REQ_WRITE, REQ_READ: begin
        entry_o.drop = !in_tex;
        entry_o.x0   = px[XW-1:0];
        entry_o.y0   = py[YW-1:0];
      end
      REQ_NEAREST: begin
        entry_o.x0 = nx[16 +: XW];
        entry_o.y0 = ny[16 +: YW];
      end
      default: begin
        entry_o.x0 = ax.i0[XW-1:0];
        entry_o.x1 = ax.i1[XW-1:0];
        entry_o.y0 = ay.i0[YW-1:0];
        entry_o.y1 = ay.i1[YW-1:0];
        entry_o.fx = ax.fr;
        entry_o.fy = ay.fr;
      end
    endcase
  end

  assign s_axis_tready = !full_i && !stat_i.clearing;
  assign push_o        = s_axis_tvalid && s_axis_tready;

endmodule

>>> hw/rtl/tss_queue.sv
// Short request queue between the front end and the back end.
// Depends on tss_pkg for the entry type and depth.
`timescale 1ns / 1ps

module tss_queue import tss_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = slot_q[rd_q];

  // Storage for the waiting requests.
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= entry_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> hw/rtl/tss_back.sv
// Back end: texel memory, clearing pass, fetch sequencer, bilinear blend, output.
// Depends on tss_pkg; takes requests from tss_queue.
`timescale 1ns / 1ps

module tss_back import tss_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  entry_t       entry_i,
  input  logic         empty_i,
  output logic         pop_o,
  output stat_t        stat_o,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0]  m_axis_tdata
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } bst_e;

  bst_e state_q, state_d;
  entry_t cur_q, cur_d;
  logic [ADDR_W-1:0] clr_q;
  logic [1:0] cnt_q, cnt_d;
  logic [31:0] res_q, res_d;
  logic [31:0] out_q;
  logic out_v_q;
  logic out_load;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;
  logic mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [31:0] mem_wdata;

  logic [XW-1:0] x_sel;
  logic [YW-1:0] y_sel;
  logic [16:0] wx_sel, wy_sel;
  logic [XW+YW:0] addr_full;
  logic issue_v, issue_last;

  logic p1_v_q, p1_last_q, p2_v_q, p2_last_q, done_q;
  logic [32:0] wgt_q;
  logic [40:0] prod_q [4];
  logic [41:0] acc_q  [4];
  logic acc_clr;
  logic [31:0] blend;

  // Texel and weight picked by the fetch counter.
  always_comb begin
    x_sel  = cnt_q[0] ? cur_q.x1 : cur_q.x0;
    y_sel  = cnt_q[1] ? cur_q.y1 : cur_q.y0;
    wx_sel = cnt_q[0] ? {1'b0, cur_q.fx} : 17'h10000 - {1'b0, cur_q.fx};
    wy_sel = cnt_q[1] ? {1'b0, cur_q.fy} : 17'h10000 - {1'b0, cur_q.fy};
    addr_full = (XW+YW+1)'(y_sel) * (XW+YW+1)'(cur_q.w) + (XW+YW+1)'(x_sel);
  end

  // Rounded blend of the four accumulated channels.
  always_comb begin
    logic [41:0] sum;
    logic [9:0]  r;
    blend = '0;
    for (int ch = 0; ch < 4; ch++) begin
      sum = acc_q[ch] + 42'h0_8000_0000;
      r   = sum[41:32];
      blend[8*ch +: 8] = (r > 10'd255) ? 8'hFF : r[7:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = addr_full[ADDR_W-1:0];
    mem_wdata  = cur_q.color;
    acc_clr    = 1'b0;
    out_load   = 1'b0;
    issue_last = (cur_q.kind != REQ_BILINEAR) || (cnt_q == 2'd3);
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        if (clr_q == ADDR_W'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cur_d   = entry_i;
          cnt_d   = '0;
          acc_clr = 1'b1;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (cur_q.kind)
          REQ_WRITE: begin
            mem_we  = !cur_q.drop;
            state_d = S_IDLE;
          end
          REQ_READ: begin
            if (cur_q.drop) begin
              res_d   = OPAQUE_BLACK;
              state_d = S_DONE;
            end else begin
              mem_re  = 1'b1;
              state_d = S_DRAIN;
            end
          end
          REQ_NEAREST: begin
            mem_re  = 1'b1;
            state_d = S_DRAIN;
          end
          default: begin
            mem_re = 1'b1;
            cnt_d  = cnt_q + 1'b1;
            if (cnt_q == 2'd3) state_d = S_DRAIN;
          end
        endcase
      end
      S_DRAIN: begin
        if (cur_q.kind != REQ_BILINEAR) begin
          if (p1_v_q) begin
            res_d   = rdata_q;
            state_d = S_DONE;
          end
        end else if (done_q) begin
          res_d   = blend;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_v_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign issue_v = mem_re;

  // Texel memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  // Blend pipeline: weight product, channel products, accumulation.
  always_ff @(posedge clk_i) begin
    logic [33:0] wp;
    wp    = 34'(wx_sel) * 34'(wy_sel);
    wgt_q <= wp[32:0];
    for (int ch = 0; ch < 4; ch++) begin
      prod_q[ch] <= 41'(rdata_q[8*ch +: 8]) * 41'(wgt_q);
      if (acc_clr)     acc_q[ch] <= '0;
      else if (p2_v_q) acc_q[ch] <= acc_q[ch] + 42'(prod_q[ch]);
    end
    cur_q <= cur_d;
    res_q <= res_d;
    if (out_load) out_q <= res_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      cnt_q     <= '0;
      p1_v_q    <= 1'b0;
      p1_last_q <= 1'b0;
      p2_v_q    <= 1'b0;
      p2_last_q <= 1'b0;
      done_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      p1_v_q    <= issue_v;
      p1_last_q <= issue_v && issue_last;
      p2_v_q    <= p1_v_q && (cur_q.kind == REQ_BILINEAR);
      p2_last_q <= p1_v_q && p1_last_q;
      done_q    <= p2_v_q && p2_last_q;
      if (out_load)           out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  assign stat_o.clearing = (state_q == S_CLEAR);
  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_q;

endmodule
